// ===== rtl/u8n1_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8n1_pkg
// shared widths, register indexes, reset values and types of the 8n1 uart
// ----------------------------------------------------------------------------
package u8n1_pkg;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned LIMIT_W  = 18;
    localparam int unsigned CFG_W    = 18;
    localparam int unsigned DATA_W   = 8;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_BIT_PERIOD       = 2'd0;
    localparam logic [1:0] CFG_TX_PRESENT       = 2'd1;
    localparam logic [1:0] CFG_RX_PRESENT       = 2'd2;
    localparam logic [1:0] CFG_START_WAIT_LIMIT = 2'd3;

    // register reset values
    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST       = 16'd104;
    localparam logic                TX_PRESENT_RST       = 1'b1;
    localparam logic                RX_PRESENT_RST       = 1'b1;
    localparam logic [LIMIT_W-1:0]  START_WAIT_LIMIT_RST = 18'd200000;

    // start + 8 data + stop
    localparam logic [3:0] TX_FRAME_BITS = 4'd10;
    localparam logic [3:0] RX_DATA_BITS  = 4'd8;

    typedef enum logic [3:0] {
        RX_IDLE = 4'b0001,
        RX_WAIT = 4'b0010,
        RX_RECV = 4'b0100,
        RX_FIN  = 4'b1000
    } rx_phase_t;

    typedef struct packed {
        logic line;
        logic busy;
    } tx_status_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic error;
    } rx_status_t;

endpackage
`default_nettype wire

// ===== rtl/uart_8n1_transceiver_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uart_8n1_transceiver_unit
// tick-driven 8n1 uart, one transmitter and one receiver, one item per tick
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      send_request, send_byte,
//                                             receive_request, line_in
//  m_       out        m_valid / m_ready      line_out, send_busy, receive_busy,
//                                             receive_done, received_byte,
//                                             receive_error, start_seen
//  cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one item per cycle while the result channel does not stall: each accepted
//  tick updates the tx and rx state and loads the result register in the same cycle
//  reset: registers that have a reset value return to it at once, no clearing pass
//  stalls: a full result register holds while m_ready is low; s_ready follows
//  an empty or draining result register, so idling on either side is free
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_send_request,
    input  wire logic [u8n1_pkg::DATA_W-1:0]     s_send_byte,
    input  wire logic                            s_receive_request,
    input  wire logic                            s_line_in,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_line_out,
    output logic                                 m_send_busy,
    output logic                                 m_receive_busy,
    output logic                                 m_receive_done,
    output logic [u8n1_pkg::DATA_W-1:0]          m_received_byte,
    output logic                                 m_receive_error,
    output logic                                 m_start_seen,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [1:0]                      cfg_index,
    input  wire logic [u8n1_pkg::CFG_W-1:0]      cfg_data
);

    // configuration registers
    logic [u8n1_pkg::PERIOD_W-1:0] bit_period_reg;
    logic                          tx_present_reg;
    logic                          rx_present_reg;
    logic [u8n1_pkg::LIMIT_W-1:0]  start_wait_limit_reg;

    // result register
    logic                          m_valid_reg;
    u8n1_pkg::tx_status_t          tx_status_reg;
    u8n1_pkg::rx_status_t          rx_status_reg;
    logic [u8n1_pkg::DATA_W-1:0]   byte_reg;
    logic                          start_seen_reg;

    u8n1_pkg::tx_status_t          tx_status;
    u8n1_pkg::rx_status_t          rx_status;
    logic [u8n1_pkg::DATA_W-1:0]   rx_byte;
    logic                          step;

    // a tick is taken whenever the result register is free or being drained
    assign s_ready   = !m_valid_reg || m_ready;
    assign step      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg       <= u8n1_pkg::BIT_PERIOD_RST;
            tx_present_reg       <= u8n1_pkg::TX_PRESENT_RST;
            rx_present_reg       <= u8n1_pkg::RX_PRESENT_RST;
            start_wait_limit_reg <= u8n1_pkg::START_WAIT_LIMIT_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                u8n1_pkg::CFG_BIT_PERIOD: begin
                    bit_period_reg <= cfg_data[u8n1_pkg::PERIOD_W-1:0];
                end
                u8n1_pkg::CFG_TX_PRESENT: begin
                    tx_present_reg <= cfg_data[0];
                end
                u8n1_pkg::CFG_RX_PRESENT: begin
                    rx_present_reg <= cfg_data[0];
                end
                u8n1_pkg::CFG_START_WAIT_LIMIT: begin
                    start_wait_limit_reg <= cfg_data[u8n1_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    u8n1_tx u_tx (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .send_request (s_send_request),
        .send_byte    (s_send_byte),
        .bit_period   (bit_period_reg),
        .tx_present   (tx_present_reg),
        .status       (tx_status)
    );

    u8n1_rx u_rx (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .receive_request  (s_receive_request),
        .line_in          (s_line_in),
        .bit_period       (bit_period_reg),
        .rx_present       (rx_present_reg),
        .start_wait_limit (start_wait_limit_reg),
        .status           (rx_status),
        .received_byte    (rx_byte)
    );

    // valid flag is control, the payload needs no reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            tx_status_reg  <= tx_status;
            rx_status_reg  <= rx_status;
            byte_reg       <= rx_byte;
            start_seen_reg <= rx_present_reg && !s_line_in;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_line_out      = tx_status_reg.line;
    assign m_send_busy     = tx_status_reg.busy;
    assign m_receive_busy  = rx_status_reg.busy;
    assign m_receive_done  = rx_status_reg.done;
    assign m_received_byte = byte_reg;
    assign m_receive_error = rx_status_reg.error;
    assign m_start_seen    = start_seen_reg;

    // a byte report and an error never share a tick
    a_done_err_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_receive_done && m_receive_error))
        else $error("receive_done and receive_error in one item");

    // the byte field is zero unless a byte is reported
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_receive_done) |-> (m_received_byte == '0))
        else $error("received_byte nonzero without receive_done");

    // the line idles high outside a frame
    a_line_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_send_busy) |-> m_line_out)
        else $error("line_out low while transmitter idle");

    // a report comes from an armed receiver
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_receive_done) |-> m_receive_busy)
        else $error("receive_done without receive_busy");

endmodule
`default_nettype wire

// ===== rtl/u8n1_tx.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8n1_tx
// transmit side: frame state advanced once per accepted tick
// ----------------------------------------------------------------------------
module u8n1_tx (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              step,
    input  wire logic                              send_request,
    input  wire logic [u8n1_pkg::DATA_W-1:0]       send_byte,
    input  wire logic [u8n1_pkg::PERIOD_W-1:0]     bit_period,
    input  wire logic                              tx_present,
    output u8n1_pkg::tx_status_t                   status
);

    logic [u8n1_pkg::DATA_W-1:0]   shift_reg, shift_next;
    logic [3:0]                    idx_reg, idx_next;
    logic [u8n1_pkg::PERIOD_W-1:0] tmr_reg, tmr_next;
    logic                          active_reg, active_next;

    logic                          start;
    logic [3:0]                    idx_cur, idx_m1, idx_inc;
    logic [u8n1_pkg::PERIOD_W:0]   tmr_inc;

    always_comb begin
        start       = send_request && !active_reg && tx_present;
        shift_next  = start ? send_byte : shift_reg;
        idx_cur     = start ? 4'd0 : idx_reg;
        idx_next    = idx_cur;
        tmr_next    = start ? '0 : tmr_reg;
        active_next = active_reg || start;
        idx_m1      = idx_cur - 4'd1;
        idx_inc     = idx_cur + 4'd1;
        tmr_inc     = {1'b0, tmr_next} + 1'b1;
        status.busy = active_next;
        status.line = 1'b1;
        if (active_next) begin
            if (idx_cur == 4'd0) begin
                status.line = 1'b0;
            end else if (idx_cur <= 4'd8) begin
                status.line = shift_next[idx_m1[2:0]];
            end
            if (tmr_inc >= {1'b0, bit_period}) begin
                tmr_next = '0;
                idx_next = idx_inc;
                if (idx_inc >= u8n1_pkg::TX_FRAME_BITS) begin
                    idx_next    = 4'd0;
                    active_next = 1'b0;
                end
            end else begin
                tmr_next = tmr_inc[u8n1_pkg::PERIOD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= '0;
            idx_reg    <= '0;
            tmr_reg    <= '0;
            active_reg <= 1'b0;
        end else if (step) begin
            shift_reg  <= shift_next;
            idx_reg    <= idx_next;
            tmr_reg    <= tmr_next;
            active_reg <= active_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/u8n1_rx.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8n1_rx
// receive side: start wait, mid-bit sampling and byte report per tick
// ----------------------------------------------------------------------------
module u8n1_rx (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              step,
    input  wire logic                              receive_request,
    input  wire logic                              line_in,
    input  wire logic [u8n1_pkg::PERIOD_W-1:0]     bit_period,
    input  wire logic                              rx_present,
    input  wire logic [u8n1_pkg::LIMIT_W-1:0]      start_wait_limit,
    output u8n1_pkg::rx_status_t                   status,
    output logic [u8n1_pkg::DATA_W-1:0]            received_byte
);

    u8n1_pkg::rx_phase_t            phase_reg, phase_next;
    logic [u8n1_pkg::LIMIT_W-1:0]   tmr_reg, tmr_next;
    logic [3:0]                     bidx_reg, bidx_next;
    logic [u8n1_pkg::DATA_W-1:0]    shift_reg, shift_next;

    logic [u8n1_pkg::LIMIT_W:0]     tmr_inc;
    logic [u8n1_pkg::LIMIT_W-1:0]   period_ext, period_half;
    logic [u8n1_pkg::LIMIT_W-1:0]   target;
    logic [3:0]                     bidx_inc;

    always_comb begin
        period_ext    = {2'b00, bit_period};
        // one and a half bit periods
        period_half   = period_ext + {3'b000, bit_period[u8n1_pkg::PERIOD_W-1:1]};
        phase_next    = phase_reg;
        tmr_next      = tmr_reg;
        bidx_next     = bidx_reg;
        shift_next    = shift_reg;
        status.error  = 1'b0;
        status.done   = 1'b0;
        received_byte = '0;

        if (receive_request && phase_reg == u8n1_pkg::RX_IDLE) begin
            if (rx_present) begin
                phase_next = u8n1_pkg::RX_WAIT;
                tmr_next   = '0;
            end else begin
                status.error = 1'b1;
            end
        end
        status.busy = (phase_next != u8n1_pkg::RX_IDLE);

        tmr_inc  = {1'b0, tmr_next} + 1'b1;
        bidx_inc = bidx_reg + 4'd1;
        target   = (bidx_reg == 4'd0) ? period_half : period_ext;

        case (phase_next)
            u8n1_pkg::RX_WAIT: begin
                if (!line_in) begin
                    phase_next = u8n1_pkg::RX_RECV;
                    tmr_next   = '0;
                    bidx_next  = 4'd0;
                    shift_next = '0;
                end else if (tmr_inc >= {1'b0, start_wait_limit}) begin
                    status.error = 1'b1;
                    phase_next   = u8n1_pkg::RX_IDLE;
                    tmr_next     = '0;
                end else begin
                    tmr_next = tmr_inc[u8n1_pkg::LIMIT_W-1:0];
                end
            end
            u8n1_pkg::RX_RECV: begin
                if (tmr_inc >= {1'b0, target}) begin
                    tmr_next = '0;
                    shift_next[bidx_reg[2:0]] = shift_reg[bidx_reg[2:0]] | line_in;
                    bidx_next = bidx_inc;
                    if (bidx_inc >= u8n1_pkg::RX_DATA_BITS) begin
                        bidx_next  = 4'd0;
                        phase_next = u8n1_pkg::RX_FIN;
                    end
                end else begin
                    tmr_next = tmr_inc[u8n1_pkg::LIMIT_W-1:0];
                end
            end
            u8n1_pkg::RX_FIN: begin
                if (tmr_inc >= {1'b0, period_half}) begin
                    tmr_next      = '0;
                    status.done   = 1'b1;
                    received_byte = shift_reg;
                    phase_next    = u8n1_pkg::RX_IDLE;
                end else begin
                    tmr_next = tmr_inc[u8n1_pkg::LIMIT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= u8n1_pkg::RX_IDLE;
            tmr_reg   <= '0;
            bidx_reg  <= '0;
            shift_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            tmr_reg   <= tmr_next;
            bidx_reg  <= bidx_next;
            shift_reg <= shift_next;
        end
    end

endmodule
`default_nettype wire

// ===== bench/uart_8n1_transceiver_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_8n1_transceiver_unit_tb
// self-checking bench for the tick-driven 8n1 uart: every accepted tick is
// run through a cycle-exact model of the transmitter and receiver, and each
// status item from the block is compared field by field with the model
// ----------------------------------------------------------------------------
module uart_8n1_transceiver_unit_tb;

    // status of one tick as the block reports it
    typedef struct packed {
        logic                        line_out;
        logic                        send_busy;
        logic                        receive_busy;
        logic                        receive_done;
        logic [u8n1_pkg::DATA_W-1:0] received_byte;
        logic                        receive_error;
        logic                        start_seen;
    } uart_status_t;

    // clock, reset and block ports; every driven input is known from time zero
    logic                        aclk              = 1'b0;
    logic                        aresetn           = 1'b0;
    logic                        s_valid           = 1'b0;
    logic                        s_ready;
    logic                        s_send_request    = 1'b0;
    logic [u8n1_pkg::DATA_W-1:0] s_send_byte       = '0;
    logic                        s_receive_request = 1'b0;
    logic                        s_line_in         = 1'b1;
    logic                        m_valid;
    logic                        m_ready           = 1'b0;
    logic                        m_line_out;
    logic                        m_send_busy;
    logic                        m_receive_busy;
    logic                        m_receive_done;
    logic [u8n1_pkg::DATA_W-1:0] m_received_byte;
    logic                        m_receive_error;
    logic                        m_start_seen;
    logic                        cfg_valid         = 1'b0;
    logic                        cfg_ready;
    logic [1:0]                  cfg_index         = u8n1_pkg::CFG_BIT_PERIOD;
    logic [u8n1_pkg::CFG_W-1:0]  cfg_data          = '0;

    // register copies, at their reset values
    logic [u8n1_pkg::PERIOD_W-1:0] cfg_period = u8n1_pkg::BIT_PERIOD_RST;
    logic                          cfg_tx_on  = u8n1_pkg::TX_PRESENT_RST;
    logic                          cfg_rx_on  = u8n1_pkg::RX_PRESENT_RST;
    logic [u8n1_pkg::LIMIT_W-1:0]  cfg_limit  = u8n1_pkg::START_WAIT_LIMIT_RST;

    // transmitter state of the model
    logic [u8n1_pkg::DATA_W-1:0]   tx_shift  = '0;
    logic [3:0]                    tx_index  = '0;
    logic [u8n1_pkg::PERIOD_W-1:0] tx_timer  = '0;
    logic                          tx_active = 1'b0;

    // receiver state of the model
    u8n1_pkg::rx_phase_t           rx_phase  = u8n1_pkg::RX_IDLE;
    logic [u8n1_pkg::LIMIT_W-1:0]  rx_timer  = '0;
    logic [3:0]                    rx_index  = '0;
    logic [u8n1_pkg::DATA_W-1:0]   rx_shift  = '0;

    // status items predicted but not yet seen on the result channel
    uart_status_t pending_status[$];
    // receive line levels still to be played out, one per tick
    logic         line_wave[$];

    int unsigned  fail_count = 0;
    // odds of an idle burst: one in idle_odds+1, zero turns idling off
    int unsigned  idle_odds  = 8;
    int unsigned  stall_left = 0;

    uart_8n1_transceiver_unit u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_send_request    (s_send_request),
        .s_send_byte       (s_send_byte),
        .s_receive_request (s_receive_request),
        .s_line_in         (s_line_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_line_out        (m_line_out),
        .m_send_busy       (m_send_busy),
        .m_receive_busy    (m_receive_busy),
        .m_receive_done    (m_receive_done),
        .m_received_byte   (m_received_byte),
        .m_receive_error   (m_receive_error),
        .m_start_seen      (m_start_seen),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model of one tick: transmitter first, then receiver
    // ------------------------------------------------------------------------
    function automatic uart_status_t uart_tick(input logic sreq,
                                               input logic [u8n1_pkg::DATA_W-1:0] sbyte,
                                               input logic rreq, input logic line);
        uart_status_t                  st;
        logic [u8n1_pkg::PERIOD_W-1:0] half;
        logic [u8n1_pkg::LIMIT_W-1:0]  target;
        logic [3:0]                    pos;
        st          = '0;
        st.line_out = 1'b1;
        half        = cfg_period >> 1;

        // a request is taken only by an idle transmitter whose line exists
        if (sreq && !tx_active && cfg_tx_on) begin
            tx_shift  = sbyte;
            tx_index  = '0;
            tx_timer  = '0;
            tx_active = 1'b1;
        end
        if (tx_active) begin
            st.send_busy = 1'b1;
            pos          = tx_index - 4'd1;
            if (tx_index == 4'd0)
                st.line_out = 1'b0;
            else if (tx_index <= 4'd8)
                st.line_out = tx_shift[pos[2:0]];
            else
                st.line_out = 1'b1;
            tx_timer = tx_timer + 1'b1;
            // a zero period still advances one bit per tick
            if (tx_timer >= cfg_period) begin
                tx_timer = '0;
                tx_index = tx_index + 4'd1;
                if (tx_index >= u8n1_pkg::TX_FRAME_BITS) begin
                    tx_index  = '0;
                    tx_active = 1'b0;
                end
            end
        end

        // arming: with no receive line the request errors at once
        if (rreq && rx_phase == u8n1_pkg::RX_IDLE) begin
            if (cfg_rx_on) begin
                rx_phase = u8n1_pkg::RX_WAIT;
                rx_timer = '0;
            end else begin
                st.receive_error = 1'b1;
            end
        end
        if (rx_phase != u8n1_pkg::RX_IDLE)
            st.receive_busy = 1'b1;
        case (rx_phase)
            u8n1_pkg::RX_WAIT: begin
                if (!line) begin
                    rx_phase = u8n1_pkg::RX_RECV;
                    rx_timer = '0;
                    rx_index = '0;
                    rx_shift = '0;
                end else begin
                    rx_timer = rx_timer + 1'b1;
                    // a limit of zero times out on the first high tick
                    if (rx_timer >= cfg_limit) begin
                        st.receive_error = 1'b1;
                        rx_phase         = u8n1_pkg::RX_IDLE;
                        rx_timer         = '0;
                    end
                end
            end
            u8n1_pkg::RX_RECV: begin
                target = (rx_index == 4'd0) ? {2'b00, cfg_period} + {2'b00, half}
                                            : {2'b00, cfg_period};
                rx_timer = rx_timer + 1'b1;
                if (rx_timer >= target) begin
                    rx_timer = '0;
                    if (line)
                        rx_shift[rx_index[2:0]] = 1'b1;
                    rx_index = rx_index + 4'd1;
                    if (rx_index >= u8n1_pkg::RX_DATA_BITS) begin
                        rx_index = '0;
                        rx_phase = u8n1_pkg::RX_FIN;
                    end
                end
            end
            u8n1_pkg::RX_FIN: begin
                target   = {2'b00, cfg_period} + {2'b00, half};
                rx_timer = rx_timer + 1'b1;
                if (rx_timer >= target) begin
                    rx_timer         = '0;
                    st.receive_done  = 1'b1;
                    st.received_byte = rx_shift;
                    rx_phase         = u8n1_pkg::RX_IDLE;
                end
            end
            default: ;
        endcase

        st.start_seen = cfg_rx_on && !line;
        return st;
    endfunction

    // register write as the block sees it
    function automatic void store_reg(input logic [1:0] idx,
                                      input logic [u8n1_pkg::CFG_W-1:0] data);
        case (idx)
            u8n1_pkg::CFG_BIT_PERIOD:       cfg_period = data[u8n1_pkg::PERIOD_W-1:0];
            u8n1_pkg::CFG_TX_PRESENT:       cfg_tx_on  = data[0];
            u8n1_pkg::CFG_RX_PRESENT:       cfg_rx_on  = data[0];
            u8n1_pkg::CFG_START_WAIT_LIMIT: cfg_limit  = data[u8n1_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %h expected %h at %0t", field, got, want, $time);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one 8n1 frame on the receive line: start, data lsb first, stop
    task automatic queue_frame(input logic [u8n1_pkg::DATA_W-1:0] data,
                               input logic [u8n1_pkg::PERIOD_W-1:0] period);
        int unsigned span;
        logic [9:0]  bits;
        span = (period == 0) ? 1 : 32'(period);
        bits = {1'b1, data, 1'b0};
        for (int b = 0; b < 10; b++)
            repeat (span) line_wave.push_back(bits[b]);
    endtask

    // sends one tick item; the line level comes from the wave, idle high when empty.
    // called right after a rising edge, returns at the edge that accepted the item
    task automatic push_tick(input logic sreq, input logic [u8n1_pkg::DATA_W-1:0] sbyte,
                             input logic rreq);
        logic line;
        line = (line_wave.size() != 0) ? line_wave.pop_front() : 1'b1;
        // random idle burst before the item
        if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_send_request    <= sreq;
        s_send_byte       <= sbyte;
        s_receive_request <= rreq;
        s_line_in         <= line;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_status.push_back(uart_tick(sreq, sbyte, rreq, line));
    endtask

    // waits for the block to drain, then writes all four registers back to back
    task automatic apply_setting(input logic [u8n1_pkg::PERIOD_W-1:0] period,
                                 input logic tx_on, input logic rx_on,
                                 input logic [u8n1_pkg::LIMIT_W-1:0] limit);
        logic [1:0]                 idx [4];
        logic [u8n1_pkg::CFG_W-1:0] val [4];
        idx[0] = u8n1_pkg::CFG_BIT_PERIOD;       val[0] = u8n1_pkg::CFG_W'(period);
        idx[1] = u8n1_pkg::CFG_TX_PRESENT;       val[1] = u8n1_pkg::CFG_W'(tx_on);
        idx[2] = u8n1_pkg::CFG_RX_PRESENT;       val[2] = u8n1_pkg::CFG_W'(rx_on);
        idx[3] = u8n1_pkg::CFG_START_WAIT_LIMIT; val[3] = u8n1_pkg::CFG_W'(limit);
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        // room for the registered result to empty, plus margin
        repeat (2) @(posedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            store_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // full frames at the shortest period: all-ones sent while all-zeros is received,
    // with requests landing on a busy transmitter and a busy receiver
    task automatic test_frame_extremes();
        apply_setting(16'd1, 1'b1, 1'b1, 18'd5);
        line_wave.delete();
        line_wave.push_back(1'b1);
        queue_frame(8'h00, 16'd1);
        push_tick(1'b1, 8'hFF, 1'b1);   // frame starts, receiver armed on a high line
        push_tick(1'b1, 8'h00, 1'b0);   // transmitter busy, ignored
        push_tick(1'b0, 8'h00, 1'b1);   // receiver busy, ignored
        repeat (9) push_tick(1'b0, 8'h00, 1'b0);
    endtask

    // both lines vanish while a frame is sent and one is received; both finish,
    // then new requests are ignored or error out
    task automatic test_presence_changes();
        apply_setting(16'd1, 1'b1, 1'b1, 18'd5);
        line_wave.delete();
        queue_frame(8'h3C, 16'd1);
        push_tick(1'b1, 8'h96, 1'b1);
        push_tick(1'b0, 8'h00, 1'b0);
        apply_setting(16'd1, 1'b0, 1'b0, 18'd5);
        repeat (9) push_tick(1'b0, 8'h00, 1'b0);
        line_wave.delete();
        line_wave.push_back(1'b0);      // low line with no receive line: no start seen
        push_tick(1'b1, 8'hA5, 1'b1);
    endtask

    // start-bit timeout: limit zero acts as one, then a limit of three high ticks
    task automatic test_start_timeout();
        apply_setting(16'd1, 1'b1, 1'b1, 18'd0);
        line_wave.delete();
        push_tick(1'b0, 8'h00, 1'b1);
        apply_setting(16'd1, 1'b1, 1'b1, 18'd3);
        push_tick(1'b0, 8'h00, 1'b1);
        repeat (2) push_tick(1'b0, 8'h00, 1'b0);
    endtask

    // widest period and limit, then a zero period that must act as one
    task automatic test_wide_settings();
        apply_setting(16'hFFFF, 1'b1, 1'b1, 18'h3FFFF);
        line_wave.delete();
        line_wave.push_back(1'b0);
        push_tick(1'b1, 8'h5A, 1'b1);
        repeat (2) push_tick(1'b0, 8'h00, 1'b0);
        apply_setting(16'd0, 1'b1, 1'b1, 18'd1);
        queue_frame(8'hC3, 16'd0);
        repeat (4) push_tick(1'b0, 8'h00, 1'b0);
    endtask

    // random phases, each under its own setting: mostly clean frames on the line,
    // with idle stretches, noise and requests at random; the last phase runs with
    // no idling on either side
    task automatic test_random_traffic(input int unsigned phases, input int unsigned ticks);
        logic [u8n1_pkg::PERIOD_W-1:0] period;
        logic [u8n1_pkg::LIMIT_W-1:0]  limit;
        int unsigned                   eff;
        int unsigned                   pick;
        logic                          sreq;
        logic                          rreq;
        for (int ph = 0; ph < phases; ph++) begin
            period = (ph == 0) ? 16'd1 : u8n1_pkg::PERIOD_W'($urandom_range(1, 6));
            limit  = $urandom_range(0, 1) ? u8n1_pkg::LIMIT_W'($urandom_range(1, 40))
                                          : u8n1_pkg::START_WAIT_LIMIT_RST;
            // alternate light and heavy idling, none at the end
            idle_odds = (ph == phases - 1) ? 0 : ((ph % 2) ? 3 : 8);
            apply_setting(period, $urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0, limit);
            line_wave.delete();
            eff = (cfg_period == 0) ? 1 : 32'(cfg_period);
            repeat (ticks) begin
                if (line_wave.size() == 0) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        queue_frame(u8n1_pkg::DATA_W'($urandom), cfg_period);
                    else if (pick < 8)
                        repeat ($urandom_range(1, 3 * eff)) line_wave.push_back(1'b1);
                    else
                        repeat ($urandom_range(1, 8))
                            line_wave.push_back(1'($urandom_range(0, 1)));
                end
                sreq = ($urandom_range(0, 5) == 0);
                // arm often when idle so most frames get caught; rarely when busy
                rreq = (rx_phase == u8n1_pkg::RX_IDLE) ? ($urandom_range(0, 2) == 0)
                                                       : ($urandom_range(0, 15) == 0);
                push_tick(sreq, u8n1_pkg::DATA_W'($urandom), rreq);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stall bursts on m_ready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // each accepted status item against the oldest prediction
    always @(posedge aclk) begin
        uart_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("item with none expected", 8'h00, 8'h00);
            end else begin
                want = pending_status.pop_front();
                if (m_line_out !== want.line_out)
                    report_mismatch("line_out", 8'(m_line_out), 8'(want.line_out));
                if (m_send_busy !== want.send_busy)
                    report_mismatch("send_busy", 8'(m_send_busy), 8'(want.send_busy));
                if (m_receive_busy !== want.receive_busy)
                    report_mismatch("receive_busy", 8'(m_receive_busy),
                                    8'(want.receive_busy));
                if (m_receive_done !== want.receive_done)
                    report_mismatch("receive_done", 8'(m_receive_done),
                                    8'(want.receive_done));
                if (m_received_byte !== want.received_byte)
                    report_mismatch("received_byte", m_received_byte, want.received_byte);
                if (m_receive_error !== want.receive_error)
                    report_mismatch("receive_error", 8'(m_receive_error),
                                    8'(want.receive_error));
                if (m_start_seen !== want.start_seen)
                    report_mismatch("start_seen", 8'(m_start_seen), 8'(want.start_seen));
            end
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial begin
        // reset held low from time zero, then released
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_frame_extremes();
        test_presence_changes();
        test_start_timeout();
        test_wide_settings();
        test_random_traffic(6, 250);

        // drain, then allow for the registered result
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
